// ----- src/cpq_pkg.sv -----
`default_nettype none

package cpq_pkg;

   localparam int unsigned SerialWidth    = 32;
   localparam int unsigned CountWidth     = 8;
   localparam int unsigned ThresholdWidth = 8;
   localparam int unsigned EventWidth     = 4;
   localparam int unsigned CsrIndexWidth  = 1;
   localparam int unsigned CsrDataWidth   = 8;

   localparam logic [ThresholdWidth-1:0] ReadThresholdReset   = 8'd3;
   localparam logic [ThresholdWidth-1:0] DetachThresholdReset = 8'd3;
   localparam logic [CountWidth-1:0]     CountMax             = 8'd255;

   localparam logic [CsrIndexWidth-1:0] CSR_READ_THRESHOLD   = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DETACH_THRESHOLD = 1'd1;

   localparam logic [1:0] PH_NONE      = 2'd0;
   localparam logic [1:0] PH_READING   = 2'd1;
   localparam logic [1:0] PH_FOUND     = 2'd2;
   localparam logic [1:0] PH_DETACHING = 2'd3;

   localparam logic [EventWidth-1:0] EV_NOTHING        = 4'd0;
   localparam logic [EventWidth-1:0] EV_NEW_DETECTED   = 4'd1;
   localparam logic [EventWidth-1:0] EV_NEW_CONFIRMED  = 4'd2;
   localparam logic [EventWidth-1:0] EV_SAME_AGAIN     = 4'd3;
   localparam logic [EventWidth-1:0] EV_DIFFERENT      = 4'd4;
   localparam logic [EventWidth-1:0] EV_NOT_AVAILABLE  = 4'd5;
   localparam logic [EventWidth-1:0] EV_DETACHED       = 4'd6;
   localparam logic [EventWidth-1:0] EV_DETACH_CONFIRM = 4'd7;
   localparam logic [EventWidth-1:0] EV_READ_STOP      = 4'd8;

   typedef struct packed {
      logic [1:0]             phase;
      logic [CountWidth-1:0]  poll_count;
      logic [SerialWidth-1:0] stored_serial;
   } state_type;

   typedef struct packed {
      logic                   card_present;
      logic [SerialWidth-1:0] card_serial;
      logic                   host_available;
   } poll_type;

endpackage

`default_nettype wire

// ----- src/cpq_channels.sv -----
`default_nettype none

interface cpq_req_if;
   logic                            valid;
   logic                            ready;
   logic                            card_present;
   logic [cpq_pkg::SerialWidth-1:0] card_serial;
   logic                            host_available;

   modport source (output valid, card_present, card_serial, host_available, input ready);
   modport sink (input valid, card_present, card_serial, host_available, output ready);
endinterface

interface cpq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cpq_pkg::EventWidth-1:0]  event_code;
   logic [cpq_pkg::SerialWidth-1:0] held_serial;

   modport source (output valid, event_code, held_serial, input ready);
   modport sink (input valid, event_code, held_serial, output ready);
endinterface

`default_nettype wire

// ----- src/card_presence_qualifier.sv -----
// The result of an accepted transaction is registered and appears in the cycle after it is accepted.
// Throughput: one poll per cycle while no result is stalled; the state update and the result register
// sit behind a single level of compare-and-select logic.
// Reset (synchronous, active high): phase none, poll count and stored serial zero,
// both thresholds 3, no result pending.
`default_nettype none

module card_presence_qualifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   cpq_req_if.sink                                  req_if,
   cpq_rsp_if.source                                rsp_if,
   input  wire logic                                csr_write_enable,
   input  wire logic [cpq_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [cpq_pkg::CsrDataWidth-1:0]    csr_write_data
);

   cpq_pkg::state_type                       state_ff, state_in;
   cpq_pkg::poll_type                        poll;
   logic [cpq_pkg::ThresholdWidth-1:0]       read_threshold_ff;
   logic [cpq_pkg::ThresholdWidth-1:0]       detach_threshold_ff;
   logic                                     rsp_valid_ff;
   logic [cpq_pkg::EventWidth-1:0]           event_code_ff, event_code_in;
   logic [cpq_pkg::SerialWidth-1:0]          held_serial_ff;
   logic                                     accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign poll.card_present   = req_if.card_present;
   assign poll.card_serial    = req_if.card_serial;
   assign poll.host_available = req_if.host_available;

   cpq_step u_step (
      .state            (state_ff),
      .poll             (poll),
      .read_threshold   (read_threshold_ff),
      .detach_threshold (detach_threshold_ff),
      .next_state       (state_in),
      .event_code       (event_code_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         read_threshold_ff   <= cpq_pkg::ReadThresholdReset;
         detach_threshold_ff <= cpq_pkg::DetachThresholdReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cpq_pkg::CSR_READ_THRESHOLD:   read_threshold_ff   <= csr_write_data;
            cpq_pkg::CSR_DETACH_THRESHOLD: detach_threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= cpq_pkg::PH_NONE;
         state_ff.poll_count    <= '0;
         state_ff.stored_serial <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_code_ff  <= event_code_in;
         held_serial_ff <= state_in.stored_serial;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_code  = event_code_ff;
   assign rsp_if.held_serial = held_serial_ff;

endmodule

`default_nettype wire

// ----- src/cpq_step.sv -----
`default_nettype none

module cpq_step (
   input  wire cpq_pkg::state_type                   state,
   input  wire cpq_pkg::poll_type                    poll,
   input  wire logic [cpq_pkg::ThresholdWidth-1:0]   read_threshold,
   input  wire logic [cpq_pkg::ThresholdWidth-1:0]   detach_threshold,
   output cpq_pkg::state_type                        next_state,
   output logic [cpq_pkg::EventWidth-1:0]            event_code
);

   logic [cpq_pkg::CountWidth-1:0] count_inc;
   logic                           serial_differs;

   assign count_inc = (state.poll_count == cpq_pkg::CountMax) ?
                      cpq_pkg::CountMax : state.poll_count + 8'd1;
   assign serial_differs = (state.stored_serial != poll.card_serial);

   always_comb begin
      next_state = state;
      event_code = cpq_pkg::EV_NOTHING;
      if (poll.card_present) begin
         if (!poll.host_available) begin
            event_code = cpq_pkg::EV_NOT_AVAILABLE;
         end else begin
            unique case (state.phase)
               cpq_pkg::PH_NONE: begin
                  next_state.poll_count = count_inc;
                  next_state.phase      = cpq_pkg::PH_READING;
                  event_code            = cpq_pkg::EV_NEW_DETECTED;
               end
               cpq_pkg::PH_READING: begin
                  next_state.poll_count = count_inc;
                  if (count_inc > read_threshold) begin
                     next_state.poll_count = '0;
                     next_state.phase      = cpq_pkg::PH_FOUND;
                     if (serial_differs) begin
                        next_state.stored_serial = poll.card_serial;
                        event_code               = cpq_pkg::EV_NEW_CONFIRMED;
                     end else begin
                        event_code = cpq_pkg::EV_SAME_AGAIN;
                     end
                  end
               end
               cpq_pkg::PH_FOUND: begin
                  if (serial_differs) begin
                     next_state.poll_count    = '0;
                     next_state.phase         = cpq_pkg::PH_READING;
                     next_state.stored_serial = poll.card_serial;
                     event_code               = cpq_pkg::EV_DIFFERENT;
                  end
               end
               default: begin
                  next_state.poll_count = 8'd1;
                  next_state.phase      = cpq_pkg::PH_READING;
                  event_code            = cpq_pkg::EV_NEW_DETECTED;
               end
            endcase
         end
      end else begin
         unique case (state.phase)
            cpq_pkg::PH_NONE: begin
               event_code = cpq_pkg::EV_NOTHING;
            end
            cpq_pkg::PH_READING: begin
               next_state.poll_count = 8'd1;
               next_state.phase      = cpq_pkg::PH_DETACHING;
               event_code            = cpq_pkg::EV_DETACHED;
            end
            cpq_pkg::PH_FOUND: begin
               next_state.poll_count = count_inc;
               next_state.phase      = cpq_pkg::PH_DETACHING;
               event_code            = cpq_pkg::EV_DETACHED;
            end
            default: begin
               next_state.poll_count = count_inc;
               if (count_inc > detach_threshold) begin
                  event_code = (state.stored_serial != '0) ?
                               cpq_pkg::EV_DETACH_CONFIRM : cpq_pkg::EV_READ_STOP;
                  next_state.stored_serial = '0;
                  next_state.phase         = cpq_pkg::PH_NONE;
                  next_state.poll_count    = '0;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/cpq_checker.sv -----
`default_nettype none

module cpq_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [cpq_pkg::EventWidth-1:0]      rsp_event_code,
   input wire logic [cpq_pkg::SerialWidth-1:0]     rsp_held_serial
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
            && $stable(rsp_held_serial);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result dropped while stalled");

   property p_stall_blocks_req;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |-> !req_ready;
   endproperty
   a_stall_blocks_req: assert property (p_stall_blocks_req)
      else $error("transaction taken while result stalled");

   property p_req_gives_rsp;
      @(posedge clock) disable iff (reset)
         req_valid && req_ready |=> rsp_valid;
   endproperty
   a_req_gives_rsp: assert property (p_req_gives_rsp) else $error("missing result");

   property p_event_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_event_code <= cpq_pkg::EV_READ_STOP;
   endproperty
   a_event_range: assert property (p_event_range) else $error("event code out of range");

   property p_removal_clears;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_event_code == cpq_pkg::EV_DETACH_CONFIRM
            || rsp_event_code == cpq_pkg::EV_READ_STOP) |-> rsp_held_serial == '0;
   endproperty
   a_removal_clears: assert property (p_removal_clears)
      else $error("serial kept after removal");

endmodule

bind card_presence_qualifier cpq_checker u_cpq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_event_code  (rsp_if.event_code),
   .rsp_held_serial (rsp_if.held_serial)
);

`default_nettype wire
